// ===== hw/rtl/ras_pkg.sv =====
package ras_pkg;

   localparam int DENOM_BITS_DEF = 24;
   localparam int RESULT_CAP_DEF = 64;

   localparam int VALUE_W  = 64;
   localparam int FRAC_W   = 57;
   localparam int ERR_W    = 33;
   localparam int TARGET_W = 32;
   localparam int MAXDEN_W = 25;
   localparam int CSR_W    = 32;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 32'd4295;
   localparam logic [MAXDEN_W-1:0] MAXDEN_RESET = 25'd1048576;

   localparam logic REG_ERROR_TARGET = 1'b0;
   localparam logic REG_MAX_DENOM    = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_LIMIT = 2'd1;
   localparam logic [1:0] STATUS_CAP   = 2'd2;
   localparam logic [1:0] STATUS_ZERO  = 2'd3;

endpackage

// ===== hw/rtl/rational_approx_search_top.sv =====
// Best rational approximation by denominator search. Pulse start while busy is low to hand
// in a signed Q32.32 value; the block then searches denominators 1, 2, 3 and so on, and emits
// each strictly better fraction as a one-cycle beat on rsp_valid, with rsp_last on the final
// beat. There is no back-pressure: sample every beat as it comes. Magnitudes below one are
// first inverted with the shared 64-step divider. Each trial denominator then passes through
// S_ROUND, S_DIFF and S_SETUP, then the same radix-2 divider forming the relative error, which
// is skipped for an oversize or zero product, or for a zero numerator when inverted, then S_JUDGE.
// A zero input answers with one beat on the next cycle and leaves busy low.
// Write the CSRs only while busy is low.
module rational_approx_search_top
   import ras_pkg::*;
#(
   parameter int DENOM_BITS = DENOM_BITS_DEF,
   parameter int RESULT_CAP = RESULT_CAP_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   output logic        [FRAC_W-1:0]   rsp_top,
   output logic        [FRAC_W-1:0]   rsp_bottom,
   output logic                       rsp_negative,
   output logic signed [ERR_W-1:0]    rsp_rel_error,
   output logic        [1:0]          rsp_status,
   output logic                       rsp_last,
   input  logic                       csr_write_en,
   input  logic                       csr_index,
   input  logic        [CSR_W-1:0]    csr_wdata
);

   localparam int DW = DENOM_BITS + 1;
   localparam int PW = VALUE_W + DENOM_BITS + 1;
   localparam int SW = (PW > 96) ? PW : 96;
   localparam int LW = (DW > MAXDEN_W) ? DW : MAXDEN_W;
   localparam int CW = $clog2(RESULT_CAP + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_YFIX  = 4'd1;
   localparam logic [3:0] S_INIT  = 4'd2;
   localparam logic [3:0] S_ROUND = 4'd3;
   localparam logic [3:0] S_DIFF  = 4'd4;
   localparam logic [3:0] S_SETUP = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_JUDGE = 4'd7;
   localparam logic [3:0] S_FINAL = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [MAXDEN_W-1:0] maxden_ff, maxden_in;
   logic                neg_ff, neg_in;
   logic                recip_ff, recip_in;
   logic [63:0]         y_ff, y_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [DW-1:0]       den_ff, den_in;
   logic [DW-1:0]       limit_ff, limit_in;
   logic [32:0]         best_ff, best_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [63:0]         n_ff, n_in;
   logic [63:0]         absd_ff, absd_in;
   logic                dneg_ff, dneg_in;
   logic [63:0]         dvd_ff, dvd_in;
   logic [63:0]         dvs_ff, dvs_in;
   logic [63:0]         rem_ff, rem_in;
   logic [5:0]          step_ff, step_in;
   logic                for_y_ff, for_y_in;
   logic                pend_ff, pend_in;
   logic [FRAC_W-1:0]   ptop_ff, ptop_in;
   logic [FRAC_W-1:0]   pbot_ff, pbot_in;
   logic [ERR_W-1:0]    perr_ff, perr_in;
   logic [1:0]          pstat_ff, pstat_in;
   logic                ovalid_ff, ovalid_in;
   logic [FRAC_W-1:0]   otop_ff, otop_in;
   logic [FRAC_W-1:0]   obot_ff, obot_in;
   logic                oneg_ff, oneg_in;
   logic [ERR_W-1:0]    oerr_ff, oerr_in;
   logic [1:0]          ostat_ff, ostat_in;
   logic                olast_ff, olast_in;

   logic [63:0]    mag;
   logic [LW-1:0]  md_ext, cap_ext, lim;
   logic [SW-1:0]  rsum;
   logic [63:0]    dl, ndl;
   logic [64:0]    rem_sh, rem_diff;
   logic [63:0]    emag;
   logic           eneg, better, done;
   logic [32:0]    errv;
   logic [CW-1:0]  cnt_next;
   logic [1:0]     fin_stat;

   always_comb begin
      state_in  = state_ff;
      target_in = target_ff;
      maxden_in = maxden_ff;
      neg_in    = neg_ff;
      recip_in  = recip_ff;
      y_in      = y_ff;
      prod_in   = prod_ff;
      den_in    = den_ff;
      limit_in  = limit_ff;
      best_in   = best_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      absd_in   = absd_ff;
      dneg_in   = dneg_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      for_y_in  = for_y_ff;
      pend_in   = pend_ff;
      ptop_in   = ptop_ff;
      pbot_in   = pbot_ff;
      perr_in   = perr_ff;
      pstat_in  = pstat_ff;
      ovalid_in = 1'b0;
      otop_in   = otop_ff;
      obot_in   = obot_ff;
      oneg_in   = oneg_ff;
      oerr_in   = oerr_ff;
      ostat_in  = ostat_ff;
      olast_in  = olast_ff;

      mag      = req_value[63] ? (64'd0 - req_value) : req_value;
      md_ext   = LW'(maxden_ff);
      cap_ext  = LW'(1) << DENOM_BITS;
      lim      = (md_ext > cap_ext) ? cap_ext : md_ext;
      if (lim == '0) begin
         lim = LW'(1);
      end
      rsum     = SW'(prod_ff) + SW'(64'h8000_0000);
      dl       = {n_ff[31:0], 32'd0} - prod_ff[63:0];
      ndl      = prod_ff[63:0] - {n_ff[31:0], 32'd0};
      rem_sh   = {rem_ff, dvd_ff[63]};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      emag     = dvd_ff;
      eneg     = recip_ff ? (!dneg_ff && absd_ff != 64'd0) : dneg_ff;
      if (emag == 64'd0) begin
         eneg = 1'b0;
      end
      better   = (emag[63:33] == '0) && (emag[32:0] < best_ff);
      errv     = eneg ? (33'd0 - emag[32:0]) : emag[32:0];
      cnt_next = cnt_ff + CW'(1);
      done     = 1'b0;
      fin_stat = STATUS_LIMIT;

      if (csr_write_en) begin
         unique case (csr_index)
            REG_ERROR_TARGET: target_in = csr_wdata[TARGET_W-1:0];
            REG_MAX_DENOM:    maxden_in = csr_wdata[MAXDEN_W-1:0];
            default:          ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (mag == 64'd0) begin
                  ovalid_in = 1'b1;
                  otop_in   = '0;
                  obot_in   = '0;
                  oneg_in   = 1'b0;
                  oerr_in   = '0;
                  ostat_in  = STATUS_ZERO;
                  olast_in  = 1'b1;
               end else begin
                  neg_in = req_value[63];
                  if (mag[63:32] == 32'd0) begin
                     recip_in = 1'b1;
                     if (mag == 64'd1) begin
                        // smallest step saturates
                        y_in     = '1;
                        state_in = S_INIT;
                     end else begin
                        dvd_in   = '1;
                        dvs_in   = mag;
                        rem_in   = '0;
                        step_in  = '0;
                        for_y_in = 1'b1;
                        state_in = S_DIV;
                     end
                  end else begin
                     recip_in = 1'b0;
                     y_in     = mag;
                     state_in = S_INIT;
                  end
               end
            end
         end
         S_YFIX: begin
            // round the quotient up to floor(2^64 / mag)
            y_in     = dvd_ff + ((rem_ff == dvs_ff - 64'd1) ? 64'd1 : 64'd0);
            state_in = S_INIT;
         end
         S_INIT: begin
            den_in   = DW'(1);
            prod_in  = PW'(y_ff);
            best_in  = 33'h1_0000_0000;
            cnt_in   = '0;
            pend_in  = 1'b0;
            limit_in = lim[DW-1:0];
            state_in = S_ROUND;
         end
         S_ROUND: begin
            n_in     = rsum[95:32];
            state_in = S_DIFF;
         end
         S_DIFF: begin
            dneg_in  = dl > 64'h8000_0000;
            absd_in  = (dl > 64'h8000_0000) ? ndl : dl;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            rem_in   = '0;
            step_in  = '0;
            for_y_in = 1'b0;
            if (recip_ff) begin
               dvd_in   = absd_ff;
               dvs_in   = n_ff;
               state_in = (n_ff != 64'd0) ? S_DIV : S_JUDGE;
               if (n_ff == 64'd0) begin
                  dvd_in = '0;
               end
            end else if (prod_ff[PW-1:64] != '0 || prod_ff[63:0] == 64'd0) begin
               dvd_in   = '0;
               state_in = S_JUDGE;
            end else begin
               dvd_in   = {absd_ff[31:0], 32'd0};
               dvs_in   = prod_ff[63:0];
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!rem_diff[64]) begin
               rem_in = rem_diff[63:0];
               dvd_in = {dvd_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh[63:0];
               dvd_in = {dvd_ff[62:0], 1'b0};
            end
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = for_y_ff ? S_YFIX : S_JUDGE;
            end
         end
         S_JUDGE: begin
            if (better) begin
               if (pend_ff) begin
                  ovalid_in = 1'b1;
                  otop_in   = ptop_ff;
                  obot_in   = pbot_ff;
                  oneg_in   = neg_ff;
                  oerr_in   = perr_ff;
                  ostat_in  = STATUS_OK;
                  olast_in  = 1'b0;
               end
               pend_in = 1'b1;
               ptop_in = recip_ff ? FRAC_W'(den_ff) : n_ff[FRAC_W-1:0];
               pbot_in = recip_ff ? n_ff[FRAC_W-1:0] : FRAC_W'(den_ff);
               perr_in = errv;
               best_in = emag[32:0];
               cnt_in  = cnt_next;
               if (emag[32:0] <= {1'b0, target_ff}) begin
                  done     = 1'b1;
                  fin_stat = STATUS_OK;
               end else if (cnt_next >= CW'(RESULT_CAP)) begin
                  done     = 1'b1;
                  fin_stat = STATUS_CAP;
               end
            end
            if (!done && den_ff >= limit_ff) begin
               done     = 1'b1;
               fin_stat = STATUS_LIMIT;
            end
            if (done) begin
               pstat_in = fin_stat;
               state_in = S_FINAL;
            end else begin
               den_in   = den_ff + DW'(1);
               prod_in  = prod_ff + PW'(y_ff);
               state_in = S_ROUND;
            end
         end
         S_FINAL: begin
            ovalid_in = 1'b1;
            otop_in   = ptop_ff;
            obot_in   = pbot_ff;
            oneg_in   = neg_ff;
            oerr_in   = perr_ff;
            ostat_in  = pstat_ff;
            olast_in  = 1'b1;
            pend_in   = 1'b0;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         target_ff <= TARGET_RESET;
         maxden_ff <= MAXDEN_RESET;
         ovalid_ff <= 1'b0;
         pend_ff   <= 1'b0;
         for_y_ff  <= 1'b0;
         cnt_ff    <= '0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         target_ff <= target_in;
         maxden_ff <= maxden_in;
         ovalid_ff <= ovalid_in;
         pend_ff   <= pend_in;
         for_y_ff  <= for_y_in;
         cnt_ff    <= cnt_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      recip_ff <= recip_in;
      y_ff     <= y_in;
      prod_ff  <= prod_in;
      den_ff   <= den_in;
      limit_ff <= limit_in;
      best_ff  <= best_in;
      n_ff     <= n_in;
      absd_ff  <= absd_in;
      dneg_ff  <= dneg_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      ptop_ff  <= ptop_in;
      pbot_ff  <= pbot_in;
      perr_ff  <= perr_in;
      pstat_ff <= pstat_in;
      otop_ff  <= otop_in;
      obot_ff  <= obot_in;
      oneg_ff  <= oneg_in;
      oerr_ff  <= oerr_in;
      ostat_ff <= ostat_in;
      olast_ff <= olast_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = ovalid_ff;
   assign rsp_top       = otop_ff;
   assign rsp_bottom    = obot_ff;
   assign rsp_negative  = oneg_ff;
   assign rsp_rel_error = oerr_ff;
   assign rsp_status    = ostat_ff;
   assign rsp_last      = olast_ff;

   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STATUS_OK)
      else $error("status set on a beat that is not last");

   a_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(RESULT_CAP))
      else $error("result count beyond cap");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> dvs_ff != 64'd0)
      else $error("divide by zero");

   a_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted item neither started nor answered");

   a_final_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINAL |-> pend_ff)
      else $error("final beat without a pending result");

endmodule

// ===== verif/rational_approx_search_top_tb.sv =====
`timescale 1ns / 1ps

module rational_approx_search_top_tb
   import ras_pkg::*;
;

   localparam int STALL_LIMIT = 400000;
   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

   typedef struct packed {
      logic [FRAC_W-1:0] top;
      logic [FRAC_W-1:0] bottom;
      logic              negative;
      logic [ERR_W-1:0]  rel_error;
      logic [1:0]        status;
      logic              last;
   } fraction_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic [FRAC_W-1:0] rsp_top, rsp_bottom;
   logic rsp_negative;
   logic signed [ERR_W-1:0] rsp_rel_error;
   logic [1:0] rsp_status;
   logic rsp_last;
   logic csr_write_en = 1'b0;
   logic csr_index = REG_ERROR_TARGET;
   logic [CSR_W-1:0] csr_wdata = '0;

   fraction_type expected_fractions[$];
   logic [31:0] model_target = TARGET_RESET;
   logic [24:0] model_max_den = MAXDEN_RESET;
   int errors = 0;
   int values_sent = 0;
   int beats_seen = 0;
   int stall_cycles = 0;
   bit steady = 1'b0;

   always #6 clock = ~clock;

   rational_approx_search_top dut (.*);

   // Expected beats for one value, searching denominators upward.
   function automatic void predict_fractions(logic [63:0] v);
      logic neg, recip, dneg, eneg;
      logic [63:0] mag, y, limit, den, best, phi, plo, rlo, rhi, n, dl, absd, emag;
      logic [127:0] prod;
      fraction_type f;
      int count;
      logic [1:0] status;
      neg = v[63];
      mag = neg ? -v : v;
      count = 0;
      status = STATUS_LIMIT;
      if (mag == 0) begin
         f = '0;
         f.status = STATUS_ZERO;
         f.last = 1'b1;
         expected_fractions.push_back(f);
         return;
      end
      recip = mag < ONE_Q32;
      if (!recip) y = mag;
      else if (mag == 1) y = '1;
      else begin
         y = 64'hFFFF_FFFF_FFFF_FFFF / mag;
         if ((64'hFFFF_FFFF_FFFF_FFFF % mag) + 64'd1 == mag) y = y + 1;
      end
      limit = model_max_den;
      if (limit > (64'd1 << 24)) limit = 64'd1 << 24;
      if (limit == 0) limit = 1;
      best = ONE_Q32;
      for (den = 1; den <= limit; den++) begin
         prod = {64'd0, den} * {64'd0, y};
         phi = prod[127:64];
         plo = prod[63:0];
         rlo = plo + 64'h8000_0000;
         rhi = phi + ((rlo < plo) ? 64'd1 : 64'd0);
         n = (rlo >> 32) | (rhi << 32);
         dl = (n << 32) - plo;
         dneg = dl > 64'h8000_0000;
         absd = dneg ? -dl : dl;
         if (recip) begin
            emag = (n != 0) ? absd / n : 64'd0;
            eneg = !dneg && absd != 0;
         end else begin
            emag = (phi != 0 || plo == 0) ? 64'd0 : (absd << 32) / plo;
            eneg = dneg;
         end
         if (emag == 0) eneg = 1'b0;
         if (emag < best) begin
            best = emag;
            f.top = recip ? den[FRAC_W-1:0] : n[FRAC_W-1:0];
            f.bottom = recip ? n[FRAC_W-1:0] : den[FRAC_W-1:0];
            f.negative = neg;
            f.rel_error = eneg ? -emag[ERR_W-1:0] : emag[ERR_W-1:0];
            f.status = STATUS_OK;
            f.last = 1'b0;
            expected_fractions.push_back(f);
            count++;
            if (best <= {32'd0, model_target}) begin status = STATUS_OK; break; end
            if (count >= RESULT_CAP_DEF) begin status = STATUS_CAP; break; end
         end
         if (den >= limit) begin status = STATUS_LIMIT; break; end
      end
      expected_fractions[$].status = status;
      expected_fractions[$].last = 1'b1;
   endfunction

   task automatic send_value(logic [63:0] v);
      logic taken;
      if (!steady)
         while ($urandom_range(99) < 35) @(negedge clock);
      @(negedge clock);
      start <= 1'b1;
      req_value <= v;
      // busy only moves at the rising edge, so read it in the low half
      forever begin
         taken = !busy;
         @(posedge clock);
         if (taken) break;
         @(negedge clock);
      end
      predict_fractions(v);
      values_sent++;
      @(negedge clock);
      start <= 1'b0;
      req_value <= {$urandom, $urandom};
   endtask

   // Hold until every beat is in and the search has finished.
   task automatic drain();
      while (expected_fractions.size() != 0 || busy) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_W-1:0] data);
      drain();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      csr_wdata <= $urandom;
      if (idx == REG_ERROR_TARGET) model_target = data;
      else model_max_den = data[24:0];
   endtask

   always @(posedge clock) begin
      fraction_type exp_f, got;
      if (!reset && rsp_valid) begin
         beats_seen++;
         got = {rsp_top, rsp_bottom, rsp_negative, rsp_rel_error, rsp_status, rsp_last};
         if (expected_fractions.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat %h", $realtime, got);
         end else begin
            exp_f = expected_fractions.pop_front();
            if (got !== exp_f) begin
               errors++;
               $display("%0t: mismatch top exp %0d got %0d, bottom exp %0d got %0d",
                        $realtime, exp_f.top, got.top, exp_f.bottom, got.bottom);
               $display("%0t:   neg exp %b got %b, err exp %h got %h,",
                        $realtime, exp_f.negative, got.negative, exp_f.rel_error,
                        got.rel_error);
               $display("%0t:   st exp %0d got %0d, last exp %b got %b",
                        $realtime, exp_f.status, got.status, exp_f.last, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("** rational_approx_search_top: FAILED **");
         $finish;
      end
   end

   task automatic test_reset_defaults();
      // integers, halves and a quarter under the reset settings
      send_value(64'd3 << 32);
      send_value(-(64'd7 << 32));
      send_value(64'h0000_0002_8000_0000);
      send_value(64'h0000_0000_8000_0000);
      send_value(-(64'h0000_0000_4000_0000));
   endtask

   task automatic test_extremes();
      write_csr(REG_MAX_DENOM, 32'd16777216);
      send_value(64'd0);
      send_value(64'd0);
      send_value(64'd1);
      send_value(-64'd1);
      send_value(64'h8000_0000_0000_0000);
      send_value(64'h7FFF_FFFF_FFFF_FFFF);
      send_value(ONE_Q32);
      send_value(ONE_Q32 - 1);
   endtask

   task automatic test_target_extremes();
      write_csr(REG_MAX_DENOM, 32'd120);
      write_csr(REG_ERROR_TARGET, 32'hFFFF_FFFF);
      send_value(64'h0000_0003_243F_6A88);
      send_value(-64'h0000_0000_1234_5678);
      write_csr(REG_ERROR_TARGET, 32'd0);
      send_value(64'h0000_0003_243F_6A88);
      send_value(64'h0000_0001_9E37_79B9);
      send_value(64'h0000_0000_5555_5555);
   endtask

   task automatic test_denominator_limit();
      write_csr(REG_ERROR_TARGET, TARGET_RESET);
      write_csr(REG_MAX_DENOM, 32'd1);
      send_value(64'h0000_0002_B7E1_5162);
      send_value(-64'h0000_0000_3000_0001);
      write_csr(REG_MAX_DENOM, 32'd0);
      send_value(64'h0000_0005_5555_5555);
      write_csr(REG_MAX_DENOM, 32'd300);
      send_value(64'h0000_0001_6A09_E667);
   endtask

   task automatic test_random();
      logic [63:0] v;
      for (int i = 0; i < 100; i++) begin
         if (i % 20 == 0) begin
            write_csr(REG_MAX_DENOM, $urandom_range(64, 1));
            case ($urandom_range(3))
               0: write_csr(REG_ERROR_TARGET, 32'd0);
               1: write_csr(REG_ERROR_TARGET, TARGET_RESET);
               2: write_csr(REG_ERROR_TARGET, $urandom_range(4000000));
               default: write_csr(REG_ERROR_TARGET, $urandom);
            endcase
         end
         steady = (i >= 40 && i < 60);
         // also hold off once until the search pipe is empty
         if (i == 70) drain();
         v = {$urandom, $urandom};
         case ($urandom_range(9))
            0: v = 64'd0;
            1, 2, 3: v = {32'd0, v[31:0]};
            4: v = {{32{v[63]}}, v[31:0]};
            5: v = v >>> $urandom_range(40);
            default: ;
         endcase
         send_value(v);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_extremes();
      test_target_extremes();
      test_denominator_limit();
      test_random();
      drain();
      repeat (100) @(negedge clock);
      $display("Sent %0d values, checked %0d fraction beats over directed and random phases,",
               values_sent, beats_seen);
      $display("covering zero, reciprocal, limit and target settings at their extremes.");
      if (errors == 0 && expected_fractions.size() == 0)
         $display("** rational_approx_search_top: PASSED **");
      else
         $display("** rational_approx_search_top: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ras_pkg.sv
hw/rtl/rational_approx_search_top.sv
verif/rational_approx_search_top_tb.sv
